### sv/cma_pkg.sv
package cma_pkg;

  // Fixed geometry of the label table and the result fields
  localparam int TABLE_SIZE       = 4;
  localparam int POS_BITS         = 2;
  localparam int LABEL_BITS       = 8;
  localparam int OUT_BITS         = 32;
  localparam int ACTIVE_BITS      = 3;
  localparam int CFG_IDX_BITS     = 3;
  localparam int CFG_DATA_BITS    = 8;

  // Defaults for the top-level parameters
  localparam int NUM_CLASSES_DEF  = 4;
  localparam int COUNT_BITS_DEF   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CLASSES_IN_USE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLASS_LABEL_A  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLASS_LABEL_B  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLASS_LABEL_C  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLASS_LABEL_D  = 3'd4;

  // Input kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic                shift;     // load neighbor record (drain)
    logic                upd;       // counted sample, this class active
    logic                is_pred;   // predicted label equals this class label
    logic                is_true;   // truth label equals this class label
    logic                pair_hit;  // this cell is the predicted position
    logic [POS_BITS-1:0] pair_idx;  // true position of the sample
  } cell_ctl_t;

endpackage

### sv/cma_in_if.sv
interface cma_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [cma_pkg::LABEL_BITS-1:0]     truth_label;
  logic [cma_pkg::LABEL_BITS-1:0]     predicted_label;

  modport source (output valid, kind, truth_label, predicted_label, input ready);
  modport sink   (input valid, kind, truth_label, predicted_label, output ready);
endinterface

### sv/cma_out_if.sv
interface cma_out_if;
  logic                             valid;
  logic                             ready;
  logic [cma_pkg::POS_BITS-1:0]     class_index;
  logic [cma_pkg::OUT_BITS-1:0]     true_pos;
  logic [cma_pkg::OUT_BITS-1:0]     false_pos;
  logic [cma_pkg::OUT_BITS-1:0]     true_neg;
  logic [cma_pkg::OUT_BITS-1:0]     false_neg;
  logic [cma_pkg::OUT_BITS-1:0]     row_count_a;
  logic [cma_pkg::OUT_BITS-1:0]     row_count_b;
  logic [cma_pkg::OUT_BITS-1:0]     row_count_c;
  logic [cma_pkg::OUT_BITS-1:0]     row_count_d;
  logic [cma_pkg::OUT_BITS-1:0]     dropped_samples;
  logic                             last;

  modport source (output valid, class_index, true_pos, false_pos, true_neg, false_neg,
                  row_count_a, row_count_b, row_count_c, row_count_d,
                  dropped_samples, last, input ready);
  modport sink   (input valid, class_index, true_pos, false_pos, true_neg, false_neg,
                  row_count_a, row_count_b, row_count_c, row_count_d,
                  dropped_samples, last, output ready);
endinterface

### sv/cma_cell.sv
// One class of the chain: one-vs-rest counters plus its confusion-matrix row.
// Record layout: slot 0 tp, 1 fp, 2 tn, 3 fn, 4+j row count for true position j.
module cma_cell #(
  parameter int NUM_CLASSES = cma_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_BITS  = cma_pkg::COUNT_BITS_DEF,
  localparam int SLOTS      = 4 + NUM_CLASSES,
  localparam int REC_BITS   = SLOTS * COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  cma_pkg::cell_ctl_t  ctl,
  input  logic [REC_BITS-1:0] shift_in,
  output logic [REC_BITS-1:0] rec
);

  localparam int SLOT_TP = 0;
  localparam int SLOT_FP = 1;
  localparam int SLOT_TN = 2;
  localparam int SLOT_FN = 3;
  localparam int SLOT_ROW = 4;

  logic [COUNT_BITS-1:0] cnt [SLOTS];

  genvar s;
  generate
    for (s = 0; s < SLOTS; s++) begin : g_slot
      logic bump;

      // Which counter this sample touches
      if (s == SLOT_TP) begin : g_tp
        assign bump = ctl.upd && ctl.is_pred && ctl.is_true;
      end else if (s == SLOT_FP) begin : g_fp
        assign bump = ctl.upd && ctl.is_pred && !ctl.is_true;
      end else if (s == SLOT_FN) begin : g_fn
        assign bump = ctl.upd && !ctl.is_pred && ctl.is_true;
      end else if (s == SLOT_TN) begin : g_tn
        assign bump = ctl.upd && !ctl.is_pred && !ctl.is_true;
      end else begin : g_row
        assign bump = ctl.pair_hit && (ctl.pair_idx == cma_pkg::POS_BITS'(s - SLOT_ROW));
      end

      // Saturating counter, or take the neighbor's value while draining
      always_ff @(posedge clk) begin
        if (rst) begin
          cnt[s] <= '0;
        end else if (ctl.shift) begin
          cnt[s] <= shift_in[s*COUNT_BITS +: COUNT_BITS];
        end else if (bump && !(&cnt[s])) begin
          cnt[s] <= cnt[s] + 1'b1;
        end
      end

      assign rec[s*COUNT_BITS +: COUNT_BITS] = cnt[s];
    end
  endgenerate

endmodule

### sv/confusion_matrix_accumulator_top.sv
// Channel  | Dir | Payload                                              | Transaction
// ---------+-----+------------------------------------------------------+-------------------
// sample   | in  | kind, truth_label, predicted_label                   | valid && ready
// result   | out | class_index, tp/fp/tn/fn, row_count_a..d, dropped,   | valid && ready
//          |     | last                                                 |
// cfg      | in  | cfg_index, cfg_data                                  | cfg_we
//
// A labelled sample updates all cells together, and the next sample follows at once
// while the block is idle. A flush is taken, then drains with NUM_CLASSES shifts
// through the cell chain; an emitting shift waits while the result register is full
// and result.ready is low. sample.ready is low during the drain.
// Results come one per active class from cell 0 of the chain.
// Synchronous reset clears all counters and loads the default class table.
module confusion_matrix_accumulator_top #(
  parameter int NUM_CLASSES = cma_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_BITS  = cma_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cma_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cma_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  cma_in_if.sink                               sample,
  cma_out_if.source                            result
);

  localparam int SLOTS    = 4 + NUM_CLASSES;
  localparam int REC_BITS = SLOTS * COUNT_BITS;
  localparam int STEP_BITS = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // Configuration registers
  logic [cma_pkg::ACTIVE_BITS-1:0] classes_in_use;
  logic [cma_pkg::LABEL_BITS-1:0]  class_label [cma_pkg::TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      classes_in_use <= cma_pkg::ACTIVE_BITS'(4);
      for (int i = 0; i < cma_pkg::TABLE_SIZE; i++) begin
        class_label[i] <= cma_pkg::LABEL_BITS'(i + 1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        cma_pkg::REG_CLASSES_IN_USE: classes_in_use <= cfg_data[cma_pkg::ACTIVE_BITS-1:0];
        cma_pkg::REG_CLASS_LABEL_A:  class_label[0] <= cfg_data;
        cma_pkg::REG_CLASS_LABEL_B:  class_label[1] <= cfg_data;
        cma_pkg::REG_CLASS_LABEL_C:  class_label[2] <= cfg_data;
        cma_pkg::REG_CLASS_LABEL_D:  class_label[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active class count, clamped to 2..NUM_CLASSES
  logic [cma_pkg::ACTIVE_BITS-1:0] n_act;
  always_comb begin
    n_act = classes_in_use;
    if (n_act < cma_pkg::ACTIVE_BITS'(2)) n_act = cma_pkg::ACTIVE_BITS'(2);
    if (n_act > cma_pkg::ACTIVE_BITS'(NUM_CLASSES)) n_act = cma_pkg::ACTIVE_BITS'(NUM_CLASSES);
  end

  state_t state, state_next;
  logic [STEP_BITS-1:0] step;

  // Label lookup: lowest active position that matches
  logic                         pred_found, truth_found;
  logic [cma_pkg::POS_BITS-1:0] pred_pos, truth_pos;
  always_comb begin
    pred_found  = 1'b0;
    truth_found = 1'b0;
    pred_pos    = '0;
    truth_pos   = '0;
    for (int i = cma_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < NUM_CLASSES && cma_pkg::ACTIVE_BITS'(i) < n_act) begin
        if (class_label[i] == sample.predicted_label) begin
          pred_found = 1'b1;
          pred_pos   = cma_pkg::POS_BITS'(i);
        end
        if (class_label[i] == sample.truth_label) begin
          truth_found = 1'b1;
          truth_pos   = cma_pkg::POS_BITS'(i);
        end
      end
    end
  end

  logic take, labelled, counted, dropped, flush_take;
  assign sample.ready = (state == ST_IDLE);
  assign take       = sample.valid && sample.ready;
  assign labelled   = take && (sample.kind == cma_pkg::KIND_SAMPLE) && (sample.truth_label != '0);
  assign counted    = labelled && pred_found && truth_found;
  assign dropped    = labelled && !(pred_found && truth_found);
  assign flush_take = take && (sample.kind == cma_pkg::KIND_FLUSH);

  // Drain sequencing
  logic out_valid;
  logic emit, slot_free, advance, drain_done;
  assign emit       = (cma_pkg::ACTIVE_BITS'(step) < n_act);
  assign slot_free  = !out_valid || result.ready;
  assign advance    = (state == ST_DRAIN) && (!emit || slot_free);
  assign drain_done = advance && (step == STEP_BITS'(NUM_CLASSES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (flush_take) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (drain_done) begin
        step <= '0;
      end else if (advance) begin
        step <= step + 1'b1;
      end
    end
  end

  // Drop counter, cleared when the drain ends
  logic [COUNT_BITS-1:0] drop_counter;
  always_ff @(posedge clk) begin
    if (rst || drain_done) begin
      drop_counter <= '0;
    end else if (dropped && !(&drop_counter)) begin
      drop_counter <= drop_counter + 1'b1;
    end
  end

  // Cell chain: samples broadcast, records shift toward cell 0 on drain
  cma_pkg::cell_ctl_t  ctl      [NUM_CLASSES];
  logic [REC_BITS-1:0] rec_bus  [NUM_CLASSES];
  logic [REC_BITS-1:0] shift_in [NUM_CLASSES];

  genvar k;
  generate
    for (k = 0; k < NUM_CLASSES; k++) begin : g_cell
      assign ctl[k].shift    = advance;
      assign ctl[k].upd      = counted && (cma_pkg::ACTIVE_BITS'(k) < n_act);
      assign ctl[k].is_pred  = (class_label[k] == sample.predicted_label);
      assign ctl[k].is_true  = (class_label[k] == sample.truth_label);
      assign ctl[k].pair_hit = counted && (pred_pos == cma_pkg::POS_BITS'(k));
      assign ctl[k].pair_idx = truth_pos;

      if (k == NUM_CLASSES - 1) begin : g_end
        assign shift_in[k] = '0;
      end else begin : g_mid
        assign shift_in[k] = rec_bus[k+1];
      end

      cma_cell #(
        .NUM_CLASSES (NUM_CLASSES),
        .COUNT_BITS  (COUNT_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl[k]),
        .shift_in (shift_in[k]),
        .rec      (rec_bus[k])
      );
    end
  endgenerate

  // Row counts of cell 0, zero for inactive true positions
  logic [cma_pkg::OUT_BITS-1:0] row_val [cma_pkg::TABLE_SIZE];
  genvar j;
  generate
    for (j = 0; j < cma_pkg::TABLE_SIZE; j++) begin : g_row
      if (j < NUM_CLASSES) begin : g_on
        assign row_val[j] = (cma_pkg::ACTIVE_BITS'(j) < n_act)
                          ? cma_pkg::OUT_BITS'(rec_bus[0][(4+j)*COUNT_BITS +: COUNT_BITS])
                          : '0;
      end else begin : g_off
        assign row_val[j] = '0;
      end
    end
  endgenerate

  // Result register
  logic                         load;
  logic [cma_pkg::POS_BITS-1:0] r_index;
  logic [cma_pkg::OUT_BITS-1:0] r_tp, r_fp, r_tn, r_fn, r_drop;
  logic [cma_pkg::OUT_BITS-1:0] r_row [cma_pkg::TABLE_SIZE];
  logic                         r_last;

  assign load = advance && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r_index <= cma_pkg::POS_BITS'(step);
      r_tp    <= cma_pkg::OUT_BITS'(rec_bus[0][0*COUNT_BITS +: COUNT_BITS]);
      r_fp    <= cma_pkg::OUT_BITS'(rec_bus[0][1*COUNT_BITS +: COUNT_BITS]);
      r_tn    <= cma_pkg::OUT_BITS'(rec_bus[0][2*COUNT_BITS +: COUNT_BITS]);
      r_fn    <= cma_pkg::OUT_BITS'(rec_bus[0][3*COUNT_BITS +: COUNT_BITS]);
      r_row   <= row_val;
      r_drop  <= cma_pkg::OUT_BITS'(drop_counter);
      r_last  <= (cma_pkg::ACTIVE_BITS'(step) + 1'b1 == n_act);
    end
  end

  assign result.valid           = out_valid;
  assign result.class_index     = r_index;
  assign result.true_pos        = r_tp;
  assign result.false_pos       = r_fp;
  assign result.true_neg        = r_tn;
  assign result.false_neg       = r_fn;
  assign result.row_count_a     = r_row[0];
  assign result.row_count_b     = r_row[1];
  assign result.row_count_c     = r_row[2];
  assign result.row_count_d     = r_row[3];
  assign result.dropped_samples = r_drop;
  assign result.last            = r_last;

endmodule

### sv/cma_checker.sv
// Port-level checks on the accumulator
module cma_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_kind,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_last,
  input logic [cma_pkg::POS_BITS-1:0]   out_index
);

  // A pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Accepting a flush blocks new samples in the next cycle
  a_flush_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == cma_pkg::KIND_FLUSH) |=> !in_ready)
    else $error("input still ready after flush");

  // A new result is only loaded while the input side is held off
  a_load_in_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared outside a drain");

  // At least two classes are active, so class 0 is never the last one
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_last && (out_index == '0)))
    else $error("last flagged on class 0");

endmodule

bind confusion_matrix_accumulator_top cma_checker u_cma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .in_kind   (sample.kind),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_last  (result.last),
  .out_index (result.class_index)
);

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 250;

  typedef logic [cma_pkg::OUT_BITS-1:0]   count_t;
  typedef logic [cma_pkg::LABEL_BITS-1:0] label_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct {
    logic [cma_pkg::POS_BITS-1:0] class_index;
    count_t                       true_pos;
    count_t                       false_pos;
    count_t                       true_neg;
    count_t                       false_neg;
    count_t                       row_count[cma_pkg::TABLE_SIZE];
    count_t                       dropped_samples;
    logic                         last;
  } class_report_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [cma_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [cma_pkg::CFG_DATA_BITS-1:0] cfg_data;

  cma_in_if  in_ch();
  cma_out_if out_ch();

  confusion_matrix_accumulator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (in_ch),
    .result    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the class table and of all tallies
  logic [cma_pkg::ACTIVE_BITS-1:0] cfg_active;
  label_t                          cfg_label[cma_pkg::TABLE_SIZE];
  count_t                          hit_count[cma_pkg::TABLE_SIZE];
  count_t                          false_alarm_count[cma_pkg::TABLE_SIZE];
  count_t                          reject_count[cma_pkg::TABLE_SIZE];
  count_t                          miss_count[cma_pkg::TABLE_SIZE];
  count_t                          pair_count[cma_pkg::TABLE_SIZE][cma_pkg::TABLE_SIZE];
  count_t                          drop_count;

  class_report_t pending_reports[$];

  int failures = 0;
  int cycles = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  function automatic count_t bump(count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic int active_classes();
    int n;
    n = int'(cfg_active);
    if (n < 2) n = 2;
    if (n > cma_pkg::NUM_CLASSES_DEF) n = cma_pkg::NUM_CLASSES_DEF;
    return n;
  endfunction

  // Lowest active position holding the label, -1 if none
  function automatic int find_position(label_t label, int n);
    for (int i = 0; i < n; i++) begin
      if (cfg_label[i] == label) return i;
    end
    return -1;
  endfunction

  task automatic clear_tallies();
    for (int i = 0; i < cma_pkg::TABLE_SIZE; i++) begin
      hit_count[i] = '0;
      false_alarm_count[i] = '0;
      reject_count[i] = '0;
      miss_count[i] = '0;
      for (int j = 0; j < cma_pkg::TABLE_SIZE; j++) pair_count[i][j] = '0;
    end
    drop_count = '0;
  endtask

  task automatic tally_sample(label_t truth, label_t pred);
    int n;
    int pp;
    int tp;
    logic is_pred;
    logic is_true;
    n = active_classes();
    // unlabelled samples leave every counter alone
    if (truth == '0) return;
    pp = find_position(pred, n);
    tp = find_position(truth, n);
    if (pp < 0 || tp < 0) begin
      drop_count = bump(drop_count);
      return;
    end
    pair_count[pp][tp] = bump(pair_count[pp][tp]);
    // one-vs-rest compares labels directly, so duplicate labels all update
    for (int j = 0; j < n; j++) begin
      is_pred = (pred == cfg_label[j]);
      is_true = (truth == cfg_label[j]);
      if (is_pred && is_true) hit_count[j] = bump(hit_count[j]);
      else if (is_pred) false_alarm_count[j] = bump(false_alarm_count[j]);
      else if (is_true) miss_count[j] = bump(miss_count[j]);
      else reject_count[j] = bump(reject_count[j]);
    end
  endtask

  task automatic emit_reports();
    int n;
    class_report_t rep;
    n = active_classes();
    for (int k = 0; k < n; k++) begin
      rep.class_index = k[cma_pkg::POS_BITS-1:0];
      rep.true_pos = hit_count[k];
      rep.false_pos = false_alarm_count[k];
      rep.true_neg = reject_count[k];
      rep.false_neg = miss_count[k];
      // columns of inactive true positions read as zero
      for (int j = 0; j < cma_pkg::TABLE_SIZE; j++) begin
        rep.row_count[j] = (j < n) ? pair_count[k][j] : '0;
      end
      rep.dropped_samples = drop_count;
      rep.last = (k == n - 1);
      pending_reports.push_back(rep);
    end
    clear_tallies();
  endtask

  // Sender: bursts of random length, random gaps between them
  task automatic send_item(logic kind, label_t truth, label_t pred);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.truth_label <= truth;
    in_ch.predicted_label <= pred;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (kind == cma_pkg::KIND_FLUSH) emit_reports();
    else tally_sample(truth, pred);
  endtask

  task automatic send_sample(label_t truth, label_t pred);
    send_item(cma_pkg::KIND_SAMPLE, truth, pred);
  endtask

  task automatic send_flush(label_t truth, label_t pred);
    send_item(cma_pkg::KIND_FLUSH, truth, pred);
  endtask

  // Sender pauses until every report is back and the block has settled
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [cma_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [cma_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cma_pkg::REG_CLASSES_IN_USE) begin
      cfg_active = data[cma_pkg::ACTIVE_BITS-1:0];
    end else begin
      cfg_label[cma_pkg::POS_BITS'(idx - cma_pkg::REG_CLASS_LABEL_A)] =
        data[cma_pkg::LABEL_BITS-1:0];
    end
  endtask

  task automatic write_table(int n, label_t a, label_t b, label_t c, label_t d);
    write_reg(cma_pkg::REG_CLASSES_IN_USE, cma_pkg::CFG_DATA_BITS'(n));
    write_reg(cma_pkg::REG_CLASS_LABEL_A, a);
    write_reg(cma_pkg::REG_CLASS_LABEL_B, b);
    write_reg(cma_pkg::REG_CLASS_LABEL_C, c);
    write_reg(cma_pkg::REG_CLASS_LABEL_D, d);
  endtask

  // Mostly a label from the active table, sometimes any byte
  function automatic label_t pick_label();
    if ($urandom_range(0, 99) < 82) return cfg_label[$urandom_range(0, active_classes() - 1)];
    return label_t'($urandom_range(0, 255));
  endfunction

  task automatic random_traffic(int count);
    label_t truth;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_flush(label_t'($urandom_range(0, 255)), label_t'($urandom_range(0, 255)));
      end else begin
        truth = ($urandom_range(0, 99) < 6) ? label_t'(0) : pick_label();
        send_sample(truth, pick_label());
      end
    end
    // leave counts behind half the time so a narrower table hides columns
    if ($urandom_range(0, 1) == 0) send_flush(label_t'($urandom_range(0, 255)), 8'h00);
    drain_results();
  endtask

  // Default table after reset, unlabelled and unknown labels
  task automatic test_default_table();
    send_sample(8'd1, 8'd1);
    send_sample(8'd2, 8'd3);
    send_sample(8'd4, 8'd4);
    send_sample(8'd3, 8'd1);
    send_sample(8'd4, 8'd2);
    send_sample(8'd1, 8'd4);
    send_sample(8'd0, 8'd1);
    send_sample(8'd0, 8'd0);
    send_sample(8'd0, 8'd200);
    send_sample(8'd9, 8'd1);
    send_sample(8'd2, 8'd255);
    send_flush(8'd0, 8'd0);
    drain_results();
  endtask

  // Label extremes, clamped class counts, inactive entries, duplicates
  task automatic test_table_extremes();
    write_table(2, 8'd0, 8'd255, 8'd7, 8'd8);
    send_sample(8'd255, 8'd0);
    send_sample(8'd255, 8'd255);
    send_sample(8'd7, 8'd255);
    send_sample(8'd255, 8'd8);
    send_flush(8'd255, 8'd255);
    drain_results();
    write_reg(cma_pkg::REG_CLASSES_IN_USE, 8'd0);
    send_sample(8'd255, 8'd0);
    send_flush(8'd0, 8'd0);
    drain_results();
    write_table(7, 8'd5, 8'd5, 8'd200, 8'd5);
    send_sample(8'd5, 8'd5);
    send_sample(8'd5, 8'd200);
    send_sample(8'd200, 8'd5);
    send_sample(8'd200, 8'd200);
    send_flush(8'd0, 8'd0);
    drain_results();
  endtask

  // Random tables, some with repeated labels, then random sample streams
  task automatic test_random_traffic();
    label_t lbl[cma_pkg::TABLE_SIZE];
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < cma_pkg::TABLE_SIZE; i++) begin
        if (i > 0 && $urandom_range(0, 3) == 0) lbl[i] = lbl[$urandom_range(0, i - 1)];
        else lbl[i] = label_t'($urandom_range(0, 255));
      end
      write_table($urandom_range(0, 7), lbl[0], lbl[1], lbl[2], lbl[3]);
      random_traffic(55);
    end
  endtask

  // Receiver holds off while the sender keeps offering transactions
  task automatic test_result_backpressure();
    write_table(4, 8'd1, 8'd2, 8'd3, 8'd4);
    hold_request = LONG_HOLD;
    burst_left = 1000;
    send_flush(8'd0, 8'd0);
    for (int i = 0; i < 30; i++) send_sample(pick_label(), pick_label());
    send_flush(8'hff, 8'hff);
    drain_results();
    for (int i = 0; i < 10; i++) send_sample(pick_label(), pick_label());
    send_flush(8'd0, 8'd0);
  endtask

  // Receiver stall pattern plus the long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 99) >= 25);
          RX_HEAVY:  out_ch.ready <= ($urandom_range(0, 99) >= 75);
          RX_TOGGLE: out_ch.ready <= ~out_ch.ready;
          default:   out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic check_field(string name, count_t want, count_t got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // Compare each result transaction with the oldest pending report
  always @(posedge clk) begin
    class_report_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no pending report, class_index %0d",
               out_ch.class_index);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("class_index", count_t'(want.class_index), count_t'(out_ch.class_index));
        check_field("true_pos", want.true_pos, out_ch.true_pos);
        check_field("false_pos", want.false_pos, out_ch.false_pos);
        check_field("true_neg", want.true_neg, out_ch.true_neg);
        check_field("false_neg", want.false_neg, out_ch.false_neg);
        check_field("row_count_a", want.row_count[0], out_ch.row_count_a);
        check_field("row_count_b", want.row_count[1], out_ch.row_count_b);
        check_field("row_count_c", want.row_count[2], out_ch.row_count_c);
        check_field("row_count_d", want.row_count[3], out_ch.row_count_d);
        check_field("dropped_samples", want.dropped_samples, out_ch.dropped_samples);
        check_field("last", count_t'(want.last), count_t'(out_ch.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = cma_pkg::KIND_SAMPLE;
    in_ch.truth_label = '0;
    in_ch.predicted_label = '0;
    cfg_active = cma_pkg::ACTIVE_BITS'(cma_pkg::NUM_CLASSES_DEF);
    for (int i = 0; i < cma_pkg::TABLE_SIZE; i++) cfg_label[i] = label_t'(i + 1);
    clear_tallies();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_default_table();
    test_table_extremes();
    test_random_traffic();
    test_result_backpressure();

    // wait out the last reports, then let the block settle
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
sv/cma_pkg.sv
sv/cma_in_if.sv
sv/cma_out_if.sv
sv/cma_cell.sv
sv/confusion_matrix_accumulator_top.sv
sv/cma_checker.sv
test/tb_top.sv
